### hdl/urlpd_pkg.sv
// Shared constants, job type and hex helpers for the URL percent decoder.
package urlpd_pkg;

  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharPct    = 8'h25;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharLowA   = 8'h61;
  localparam logic [7:0] CharLowF   = 8'h66;
  localparam logic [7:0] CharUpA    = 8'h41;
  localparam logic [7:0] CharUpF    = 8'h46;
  localparam logic [7:0] Ten        = 8'd10;

  // Escape state codes.
  localparam logic [1:0] ModePlain  = 2'd0;
  localparam logic [1:0] ModePct    = 2'd1;
  localparam logic [1:0] ModeDigit  = 2'd2;

  // Job queue between front and back.
  localparam int QDepth = 2;
  localparam int QAw    = $clog2(QDepth);
  localparam int QCw    = QAw + 1;

  localparam int JobBytes = 3;
  localparam int JobIdxW  = $clog2(JobBytes);

  // One accepted beat turned into up to three output bytes.
  typedef struct packed {
    logic [JobIdxW-1:0]       cnt;
    logic                     last;
    logic [JobBytes-1:0][7:0] bytes;
  } job_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= CharZero && c <= CharNine) ||
             (c >= CharLowA && c <= CharLowF) ||
             (c >= CharUpA  && c <= CharUpF);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= CharZero && c <= CharNine) begin
      t = c - CharZero;
    end else if (c >= CharLowA && c <= CharLowF) begin
      t = c - CharLowA + Ten;
    end else if (c >= CharUpA && c <= CharUpF) begin
      t = c - CharUpA + Ten;
    end
    hex_value = t[3:0];
  endfunction

endpackage

### hdl/urlpd_front.sv
// Front end: tracks the escape state and turns each input beat into a byte job.
module urlpd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          in_byte_i,
  input  logic                is_last_i,
  output logic                push_o,
  output urlpd_pkg::job_t     job_o
);

  logic [1:0] mode_q, mode_d;
  logic [7:0] held_q, held_d;
  logic [urlpd_pkg::JobIdxW-1:0] n;
  logic       do_plain;
  urlpd_pkg::job_t job;

  always_comb begin
    mode_d   = mode_q;
    held_d   = held_q;
    job      = '0;
    n        = '0;
    do_plain = 1'b0;

    case (mode_q)
      urlpd_pkg::ModePct: begin
        if (urlpd_pkg::is_hex(in_byte_i)) begin
          held_d = in_byte_i;
          mode_d = urlpd_pkg::ModeDigit;
        end else begin
          mode_d = urlpd_pkg::ModePlain;
          job.bytes[n] = urlpd_pkg::CharPct;
          n = n + 1'b1;
          do_plain = 1'b1;
        end
      end
      urlpd_pkg::ModeDigit: begin
        mode_d = urlpd_pkg::ModePlain;
        held_d = 8'd0;
        if (urlpd_pkg::is_hex(in_byte_i)) begin
          job.bytes[n] = {urlpd_pkg::hex_value(held_q), urlpd_pkg::hex_value(in_byte_i)};
          n = n + 1'b1;
        end else begin
          job.bytes[n] = urlpd_pkg::CharPct;
          n = n + 1'b1;
          job.bytes[n] = held_q;
          n = n + 1'b1;
          do_plain = 1'b1;
        end
      end
      default: begin
        mode_d   = urlpd_pkg::ModePlain;
        do_plain = 1'b1;
      end
    endcase

    if (do_plain) begin
      if (in_byte_i == urlpd_pkg::CharPlus) begin
        job.bytes[n] = urlpd_pkg::CharSpace;
        n = n + 1'b1;
      end else if (in_byte_i == urlpd_pkg::CharPct) begin
        mode_d = urlpd_pkg::ModePct;
      end else begin
        job.bytes[n] = in_byte_i;
        n = n + 1'b1;
      end
    end

    // Flush a cut escape at end of string.
    if (is_last_i) begin
      if (mode_d == urlpd_pkg::ModePct) begin
        job.bytes[n] = urlpd_pkg::CharPct;
        n = n + 1'b1;
      end else if (mode_d == urlpd_pkg::ModeDigit) begin
        job.bytes[n] = urlpd_pkg::CharPct;
        n = n + 1'b1;
        job.bytes[n] = held_d;
        n = n + 1'b1;
      end
      mode_d = urlpd_pkg::ModePlain;
      held_d = 8'd0;
    end

    job.cnt  = n;
    job.last = is_last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= urlpd_pkg::ModePlain;
      held_q <= 8'd0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      held_q <= held_d;
    end
  end

  assign push_o = accept_i && (n != '0);
  assign job_o  = job;

endmodule

### hdl/urlpd_queue.sv
// Short job queue between the front end and the output sequencer.
module urlpd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  urlpd_pkg::job_t job_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            head_valid_o,
  output urlpd_pkg::job_t head_o
);

  urlpd_pkg::job_t mem_q [urlpd_pkg::QDepth];
  logic [urlpd_pkg::QAw-1:0] wptr_q, rptr_q;
  logic [urlpd_pkg::QCw-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == urlpd_pkg::QAw'(urlpd_pkg::QDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == urlpd_pkg::QAw'(urlpd_pkg::QDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign full_o       = (cnt_q == urlpd_pkg::QCw'(urlpd_pkg::QDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rptr_q];

endmodule

### hdl/urlpd_back.sv
// Back end: walks the bytes of each job into a registered output beat.
module urlpd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  urlpd_pkg::job_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o
);

  logic [urlpd_pkg::JobIdxW-1:0] idx_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       load;
  logic       at_end;

  assign load   = !out_valid_q || !out_stall_i;
  assign at_end = (idx_q == head_i.cnt - 1'b1);
  assign pop_o  = load && head_valid_i && at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (load) begin
      out_valid_q <= head_valid_i;
      if (head_valid_i) begin
        idx_q <= at_end ? '0 : idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && head_valid_i) begin
      out_byte_q <= head_i.bytes[idx_q];
      out_last_q <= head_i.last && at_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

### hdl/url_percent_decoder_core.sv
// Top level of the URL percent decoder: front end, job queue and output sequencer.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------
//   in      | sink      | in_valid_i / in_stall_o | in_byte_i, is_last_i
//   out     | source    | out_valid_o / out_stall_i | out_byte_o, out_last_o
//
// Each input beat is decoded in the cycle it is accepted into a job of zero to
// three bytes; the output sequencer sends one byte per cycle while the output is
// not stalled, so a beat that yields one byte sustains one beat per cycle.
// The two-entry job queue stalls the input only when full, i.e. while a flush
// of a broken escape or a stalled output holds the sequencer.
// Reset clears the escape state, the queue pointers and the output valid flag at once.
module url_percent_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  logic            accept;
  logic            push;
  logic            pop;
  logic            full;
  logic            head_valid;
  urlpd_pkg::job_t job;
  urlpd_pkg::job_t head;

  // Accept whenever the queue has room; the front end never waits otherwise.
  assign accept     = in_valid_i && !full;
  assign in_stall_o = full;

  // Classify the beat and advance the escape state.
  urlpd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .is_last_i (is_last_i),
    .push_o    (push),
    .job_o     (job)
  );

  // Decouple the front end from the output side.
  urlpd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .job_i        (job),
    .pop_i        (pop),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // Drain each job one byte per beat; drop the job after its final byte.
  urlpd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .out_last_o   (out_last_o)
  );

endmodule

### hdl/urlpd_checker.sv
// Port-level checks for the URL percent decoder and their bind to the top level.
module urlpd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       out_last_o
);

  // No output beat once reset has been seen at an edge.
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_byte_o) && $stable(out_last_o))
    else $error("stalled output beat changed");

  // A full queue always has a beat waiting at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // The queue fills only on an accepted input beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall rose without an accepted beat");

endmodule

bind url_percent_decoder_core urlpd_checker u_urlpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_byte_o  (out_byte_o),
  .out_last_o  (out_last_o)
);
